/* src/fifo_handoff_mutex_macros.svh */
// ----------------------------------------------------------------------------
// fifo_handoff_mutex_macros.svh
// Assertion macros shared by the mutex RTL. With SYNTH defined they expand
// to nothing.
// ----------------------------------------------------------------------------
`ifndef FIFO_HANDOFF_MUTEX_MACROS_SVH
`define FIFO_HANDOFF_MUTEX_MACROS_SVH
`ifndef SYNTH
// Property that must hold at every rising clock edge outside reset.
`define FHM_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// Condition that must never be seen outside reset.
`define FHM_NEVER(lbl, clk, rst, expr, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);
`else
`define FHM_ASSERT(lbl, clk, rst, prop, msg)
`define FHM_NEVER(lbl, clk, rst, expr, msg)
`endif
`endif

/* src/fhm_pkg.sv */
// ----------------------------------------------------------------------------
// fhm_pkg
// Types and constants of the FIFO handoff mutex.
// ----------------------------------------------------------------------------
package fhm_pkg;

   // Default number of tasks and the fixed field widths.
   localparam int MAX_TASKS_DEF = 64;
   localparam int TASK_W        = 6;
   localparam int CMD_W         = 2;
   localparam int STATUS_W      = 4;
   localparam int TASK_IDS      = 2 ** TASK_W;

   typedef enum logic [CMD_W-1:0] {
      CMD_LOCK   = 2'd0,
      CMD_UNLOCK = 2'd1,
      CMD_CHECK  = 2'd2
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      STS_GRANTED   = 4'd0,
      STS_QUEUED    = 4'd1,
      STS_FREED     = 4'd2,
      STS_HANDOFF   = 4'd3,
      STS_HELD_OK   = 4'd4,
      STS_RECURSIVE = 4'd5,
      STS_NOT_OWNER = 4'd6,
      STS_BOOT_CONT = 4'd7,
      STS_BAD_CTX   = 4'd8
   } status_type;

   // Controller states, one-hot.
   typedef enum logic [2:0] {
      ST_CLEAR = 3'b001,
      ST_IDLE  = 3'b010,
      ST_EXEC  = 3'b100
   } state_type;

   // One request word as captured at accept.
   typedef struct packed {
      logic [CMD_W-1:0]  cmd;
      logic [TASK_W-1:0] task_id;
      logic              context_ok;
   } req_word_type;

   // Mutex state seen by the decision logic.
   typedef struct packed {
      logic              held;
      logic [TASK_W-1:0] owner;
      logic              q_empty;
      logic              q_full;
      logic              flag;
      logic [TASK_W-1:0] head_task;
   } mtx_state_type;

   // Outcome of one request: the result and the state updates.
   typedef struct packed {
      status_type        status;
      logic              wake_valid;
      logic [TASK_W-1:0] wake_task;
      logic              held_next;
      logic [TASK_W-1:0] owner_next;
      logic              flag_we;
      logic              flag_val;
      logic              push;
      logic              pop;
   } decision_type;

   // One response word.
   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [TASK_W-1:0]   wake_task;
      logic                wake_valid;
      logic [TASK_W-1:0]   owner_now;
      logic                owned_now;
   } rsp_word_type;

endpackage

/* src/fhm_channels.sv */
// ----------------------------------------------------------------------------
// fhm_channels
// Valid/ready channels for mutex requests and responses.
// ----------------------------------------------------------------------------
interface fhm_req_if;
   logic                        valid;
   logic                        ready;
   logic [fhm_pkg::CMD_W-1:0]   cmd;
   logic [fhm_pkg::TASK_W-1:0]  task_id;
   logic                        context_ok;

   modport source (output valid, cmd, task_id, context_ok, input ready);
   modport sink   (input valid, cmd, task_id, context_ok, output ready);
endinterface

interface fhm_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [fhm_pkg::STATUS_W-1:0] status;
   logic [fhm_pkg::TASK_W-1:0]   wake_task;
   logic                         wake_valid;
   logic [fhm_pkg::TASK_W-1:0]   owner_now;
   logic                         owned_now;

   modport source (output valid, status, wake_task, wake_valid, owner_now, owned_now,
                   input ready);
   modport sink   (input valid, status, wake_task, wake_valid, owner_now, owned_now,
                   output ready);
endinterface

/* src/fhm_ram.sv */
// ----------------------------------------------------------------------------
// fhm_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module fhm_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 2
) (
   input  logic                             clock,
   input  logic                             we,
   input  logic [$clog2(DEPTH)-1:0]         waddr,
   input  logic [WIDTH-1:0]                 wdata,
   input  logic                             re,
   input  logic [$clog2(DEPTH)-1:0]         raddr,
   output logic [WIDTH-1:0]                 rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
   end

   // Read port; data holds until the next read.
   always_ff @(posedge clock) begin
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

/* src/fhm_decide.sv */
// ----------------------------------------------------------------------------
// fhm_decide
// Decides the result of one request and the state updates it implies.
// ----------------------------------------------------------------------------
module fhm_decide #(
   parameter int MAX_TASKS = fhm_pkg::MAX_TASKS_DEF
) (
   input  fhm_pkg::req_word_type  word,
   input  fhm_pkg::mtx_state_type mtx,
   output fhm_pkg::decision_type  dec
);

   // Every id the field can carry is in range when there are enough tasks.
   localparam logic ALL_IN = (MAX_TASKS >= fhm_pkg::TASK_IDS);

   logic in_range;
   logic owns;
   logic is_owner;

   assign in_range = ALL_IN || (32'(word.task_id) < 32'(MAX_TASKS));
   assign owns     = mtx.held && (mtx.owner == word.task_id);
   assign is_owner = owns && mtx.flag;

   always_comb begin
      dec            = '0;
      dec.status     = fhm_pkg::STS_BAD_CTX;
      dec.held_next  = mtx.held;
      dec.owner_next = mtx.owner;

      if (!word.context_ok || !in_range) begin
         dec.status = fhm_pkg::STS_BAD_CTX;
      end else begin
         unique case (fhm_pkg::cmd_type'(word.cmd))
            fhm_pkg::CMD_LOCK: begin
               // A task that holds or waits already is refused first.
               priority if (owns || mtx.flag) begin
                  dec.status = fhm_pkg::STS_RECURSIVE;
               end else if (!mtx.held) begin
                  dec.status     = fhm_pkg::STS_GRANTED;
                  dec.held_next  = 1'b1;
                  dec.owner_next = word.task_id;
                  dec.flag_we    = 1'b1;
                  dec.flag_val   = 1'b1;
               end else if (word.task_id == '0) begin
                  dec.status = fhm_pkg::STS_BOOT_CONT;
               end else if (mtx.q_full) begin
                  dec.status = fhm_pkg::STS_RECURSIVE;
               end else begin
                  dec.status   = fhm_pkg::STS_QUEUED;
                  dec.push     = 1'b1;
                  dec.flag_we  = 1'b1;
                  dec.flag_val = 1'b1;
               end
            end
            fhm_pkg::CMD_UNLOCK: begin
               if (!is_owner) begin
                  dec.status = fhm_pkg::STS_NOT_OWNER;
               end else begin
                  dec.flag_we  = 1'b1;
                  dec.flag_val = 1'b0;
                  // Hand straight to the oldest waiter, or free the mutex.
                  if (!mtx.q_empty) begin
                     dec.status     = fhm_pkg::STS_HANDOFF;
                     dec.pop        = 1'b1;
                     dec.owner_next = mtx.head_task;
                     dec.wake_task  = mtx.head_task;
                     dec.wake_valid = 1'b1;
                  end else begin
                     dec.status     = fhm_pkg::STS_FREED;
                     dec.held_next  = 1'b0;
                     dec.owner_next = '0;
                  end
               end
            end
            fhm_pkg::CMD_CHECK: begin
               dec.status = is_owner ? fhm_pkg::STS_HELD_OK : fhm_pkg::STS_NOT_OWNER;
            end
            default: begin
               dec.status = fhm_pkg::STS_NOT_OWNER;
            end
         endcase
      end
   end

endmodule

/* src/fifo_handoff_mutex.sv */
// ----------------------------------------------------------------------------
// fifo_handoff_mutex
// Hardware mutex with a FIFO wait queue and direct handoff to the oldest
// waiter.
//
//   Channel  Dir  Words carried
//   req      in   cmd, task_id, context_ok
//   rsp      out  status, wake_task, wake_valid, owner_now, owned_now
//
// At accept a request reads the task flag memory and the queue head
// memory; in the EXEC state it is decided and, once it fires, written back.
// One request is in flight at a time: a new word is not accepted until
// the last one has fired, and a stalled response side holds the flow.
// After reset a clearing pass zeroes every entry of the flag memory;
// req.ready stays low meanwhile.
// A stalled response holds the finished request until the slot frees.
// ----------------------------------------------------------------------------
`include "fifo_handoff_mutex_macros.svh"

module fifo_handoff_mutex #(
   parameter int MAX_TASKS = fhm_pkg::MAX_TASKS_DEF
) (
   input  logic      clock,
   input  logic      reset,
   fhm_req_if.sink   req,
   fhm_rsp_if.source rsp
);

   localparam int IDX_W = $clog2(MAX_TASKS);
   localparam int CNT_W = $clog2(MAX_TASKS + 1);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_TASKS - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(MAX_TASKS);

   fhm_pkg::state_type     state_ff, state_in;
   logic [IDX_W-1:0]       clr_ff, clr_in;
   logic                   held_ff;
   logic [fhm_pkg::TASK_W-1:0] owner_ff;
   logic [IDX_W-1:0]       head_ff;
   logic [IDX_W-1:0]       tail_ff;
   logic [CNT_W-1:0]       count_ff;
   fhm_pkg::req_word_type  word_ff;
   logic                   rsp_valid_ff;
   fhm_pkg::rsp_word_type  rsp_word_ff;

   fhm_pkg::req_word_type  req_word;
   fhm_pkg::mtx_state_type mtx;
   fhm_pkg::decision_type  dec;

   logic                   accept;
   logic                   fire;
   logic                   clearing;
   logic                   flag_we;
   logic [IDX_W-1:0]       flag_waddr;
   logic                   flag_wdata;
   logic                   flag_rdata;
   logic [fhm_pkg::TASK_W-1:0] queue_rdata;

   function automatic logic [IDX_W-1:0] ring_next(input logic [IDX_W-1:0] i);
      return (i == LAST_IDX) ? '0 : i + 1'b1;
   endfunction

   // Handshake.
   assign clearing  = (state_ff == fhm_pkg::ST_CLEAR);
   assign req.ready = (state_ff == fhm_pkg::ST_IDLE);
   assign accept    = req.valid && req.ready;
   assign fire      = (state_ff == fhm_pkg::ST_EXEC) && (!rsp_valid_ff || rsp.ready);

   assign req_word.cmd        = req.cmd;
   assign req_word.task_id    = req.task_id;
   assign req_word.context_ok = req.context_ok;

   // Controller.
   always_comb begin
      state_in = state_ff;
      clr_in   = clr_ff;
      unique case (state_ff)
         fhm_pkg::ST_CLEAR: begin
            clr_in = ring_next(clr_ff);
            if (clr_ff == LAST_IDX) begin
               state_in = fhm_pkg::ST_IDLE;
            end
         end
         fhm_pkg::ST_IDLE: begin
            if (accept) begin
               state_in = fhm_pkg::ST_EXEC;
            end
         end
         fhm_pkg::ST_EXEC: begin
            if (fire) begin
               state_in = fhm_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = fhm_pkg::ST_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= fhm_pkg::ST_CLEAR;
         clr_ff   <= '0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
      end
   end

   // Task flag memory: cleared after reset, then read at accept and
   // written back when the request completes.
   assign flag_we    = clearing || (fire && dec.flag_we);
   assign flag_waddr = clearing ? clr_ff : IDX_W'(word_ff.task_id);
   assign flag_wdata = clearing ? 1'b0 : dec.flag_val;

   fhm_ram #(
      .WIDTH (1),
      .DEPTH (MAX_TASKS)
   ) u_flag_ram (
      .clock (clock),
      .we    (flag_we),
      .waddr (flag_waddr),
      .wdata (flag_wdata),
      .re    (accept),
      .raddr (IDX_W'(req.task_id)),
      .rdata (flag_rdata)
   );

   // Wait queue ring: push at the tail, head entry read at accept.
   fhm_ram #(
      .WIDTH (fhm_pkg::TASK_W),
      .DEPTH (MAX_TASKS)
   ) u_queue_ram (
      .clock (clock),
      .we    (fire && dec.push),
      .waddr (tail_ff),
      .wdata (word_ff.task_id),
      .re    (accept),
      .raddr (head_ff),
      .rdata (queue_rdata)
   );

   // Decision on the captured request.
   assign mtx.held      = held_ff;
   assign mtx.owner     = owner_ff;
   assign mtx.q_empty   = (count_ff == '0);
   assign mtx.q_full    = (count_ff >= FULL_CNT);
   assign mtx.flag      = flag_rdata;
   assign mtx.head_task = queue_rdata;

   fhm_decide #(
      .MAX_TASKS (MAX_TASKS)
   ) u_decide (
      .word (word_ff),
      .mtx  (mtx),
      .dec  (dec)
   );

   // Capture the request word.
   always_ff @(posedge clock) begin
      if (accept) begin
         word_ff <= req_word;
      end
   end

   // Mutex and queue registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff  <= 1'b0;
         owner_ff <= '0;
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else if (fire) begin
         held_ff  <= dec.held_next;
         owner_ff <= dec.owner_next;
         if (dec.push) begin
            tail_ff  <= ring_next(tail_ff);
            count_ff <= count_ff + 1'b1;
         end else if (dec.pop) begin
            head_ff  <= ring_next(head_ff);
            count_ff <= count_ff - 1'b1;
         end
      end
   end

   // Response register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_word_ff.status     <= dec.status;
         rsp_word_ff.wake_task  <= dec.wake_task;
         rsp_word_ff.wake_valid <= dec.wake_valid;
         rsp_word_ff.owner_now  <= dec.held_next ? dec.owner_next : '0;
         rsp_word_ff.owned_now  <= dec.held_next;
      end
   end

   assign rsp.valid      = rsp_valid_ff;
   assign rsp.status     = rsp_word_ff.status;
   assign rsp.wake_task  = rsp_word_ff.wake_task;
   assign rsp.wake_valid = rsp_word_ff.wake_valid;
   assign rsp.owner_now  = rsp_word_ff.owner_now;
   assign rsp.owned_now  = rsp_word_ff.owned_now;

   // Checks on queue bookkeeping and handoff responses.
   `FHM_NEVER(a_count_bound, clock, reset, count_ff > FULL_CNT, "queue count over depth")
   `FHM_ASSERT(a_free_empty, clock, reset, !held_ff |-> count_ff == '0, "waiters on free mutex")
   `FHM_ASSERT(a_empty_ptrs, clock, reset, count_ff == '0 |-> head_ff == tail_ff, "ring pointers")
   `FHM_ASSERT(a_handoff, clock, reset, (rsp.valid && rsp.wake_valid) |-> (rsp.owned_now && rsp.owner_now == rsp.wake_task), "handoff owner mismatch")

endmodule
